>>> rtl/vws_pkg.sv
// Shared types, constants and helpers for the voltammetry waveform sequencer.
// No dependencies; every other file of the block imports this package.

package vws_pkg;

    localparam int DAC_BITS  = 12;
    localparam int VOLT_W    = 17;
    localparam int CFG_V_W   = 15;
    localparam int STEP_W    = 14;
    localparam int PERIOD_W  = 16;
    localparam int CYC_W     = 8;
    localparam int OUT_V_W   = 16;
    localparam int ACC_W     = 40;
    localparam int FRAC_BITS = 16;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam longint unsigned DAC_MAX_U = (64'd1 << DAC_BITS) - 64'd1;
    localparam longint unsigned GAIN_U    = (DAC_MAX_U * 64'd65536 + 64'd8250) / 64'd16500;
    localparam longint unsigned OFFSET_U  =
        (DAC_MAX_U * 64'd1703 * 64'd65536 + 64'd2500) / 64'd5000;

    localparam logic signed [ACC_W-1:0] GAIN_Q16   = ACC_W'(GAIN_U);
    localparam logic signed [ACC_W-1:0] OFFSET_Q16 = ACC_W'(OFFSET_U);
    localparam logic [ACC_W-FRAC_BITS-1:0] DAC_MAX_WIDE = (ACC_W-FRAC_BITS)'(DAC_MAX_U);
    localparam logic [DAC_BITS-1:0] DAC_MAX = DAC_BITS'(DAC_MAX_U);

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_ABORT = 2'd2;

    localparam logic [1:0] TECH_LINEAR = 2'd0;
    localparam logic [1:0] TECH_CYCLIC = 2'd1;
    localparam logic [1:0] TECH_SQUARE = 2'd2;

    localparam logic [2:0] REG_STEP_PERIOD     = 3'd0;
    localparam logic [2:0] REG_STEP_SIZE       = 3'd1;
    localparam logic [2:0] REG_START_VOLTAGE   = 3'd2;
    localparam logic [2:0] REG_END_VOLTAGE     = 3'd3;
    localparam logic [2:0] REG_FIRST_VERTEX    = 3'd4;
    localparam logic [2:0] REG_SECOND_VERTEX   = 3'd5;
    localparam logic [2:0] REG_CYCLE_COUNT     = 3'd6;
    localparam logic [2:0] REG_PULSE_AMPLITUDE = 3'd7;

    localparam logic [1:0] SEG_FIRST  = 2'd0;
    localparam logic [1:0] SEG_SECOND = 2'd1;
    localparam logic [1:0] SEG_LAST   = 2'd2;

    typedef enum logic [1:0] {
        OP_START,
        OP_TICK,
        OP_ABORT
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [1:0] technique;
    } op_t;

    typedef struct packed {
        logic signed [VOLT_W-1:0] voltage;
        logic                     sample;
        logic                     done;
        logic                     last;
    } point_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] step_period;
        logic [STEP_W-1:0]   step_size;
        logic [CFG_V_W-1:0]  start_voltage;
        logic [CFG_V_W-1:0]  end_voltage;
        logic [CFG_V_W-1:0]  first_vertex;
        logic [CFG_V_W-1:0]  second_vertex;
        logic [CYC_W-1:0]    cycle_count;
        logic [STEP_W-1:0]   pulse_amplitude;
    } cfg_t;

    function automatic logic signed [VOLT_W-1:0] ext_volt(input logic [CFG_V_W-1:0] v);
        return VOLT_W'($signed(v));
    endfunction

endpackage

>>> rtl/vws_front.sv
// Front end: drops unused commands and starts of an unused technique and
// turns the rest of the input into queued operations. Depends on vws_pkg.

module vws_front import vws_pkg::*; (
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [1:0] s_technique,
    input  logic       q_full,
    output logic       push,
    output op_t        push_op
);

    logic keep;

    assign s_ready = !q_full;

    always_comb begin
        keep            = 1'b0;
        push_op.kind    = OP_TICK;
        push_op.technique = s_technique;
        unique case (s_command)
            CMD_START: begin
                keep         = (s_technique == TECH_LINEAR) || (s_technique == TECH_CYCLIC)
                               || (s_technique == TECH_SQUARE);
                push_op.kind = OP_START;
            end
            CMD_TICK: begin
                keep         = 1'b1;
                push_op.kind = OP_TICK;
            end
            CMD_ABORT: begin
                keep         = 1'b1;
                push_op.kind = OP_ABORT;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = s_valid && s_ready && keep;

endmodule

>>> rtl/vws_queue.sv
// Two-entry operation queue between the front end and the sequencer.
// Depends on vws_pkg.

module vws_queue import vws_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output logic op_valid,
    output op_t  op
);

    op_t        entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign op_valid = (count_reg != 2'd0);
    assign op       = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

>>> rtl/vws_back.sv
// Sequencer: holds the sweep state, carries out queued operations one at a
// time and issues waveform points towards the DAC stage. Depends on vws_pkg.

module vws_back import vws_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  cfg_t   cfg,
    input  logic   op_valid,
    input  op_t    op,
    output logic   pop,
    output logic   pt_valid,
    output point_t pt,
    input  logic   pt_ready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK,
        ST_SQ_FWD,
        ST_SQ_REV
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic                     running_reg;
    logic                     running_next;
    logic [1:0]               tech_reg;
    logic [1:0]               tech_next;
    logic [1:0]               seg_reg;
    logic [1:0]               seg_next;
    logic                     up_reg;
    logic                     up_next;
    logic signed [VOLT_W-1:0] volt_reg;
    logic signed [VOLT_W-1:0] volt_next;
    logic [PERIOD_W-1:0]      count_reg;
    logic [PERIOD_W-1:0]      count_next;
    logic [CYC_W-1:0]         cyc_reg;
    logic [CYC_W-1:0]         cyc_next;

    logic signed [VOLT_W-1:0] start_v;
    logic signed [VOLT_W-1:0] end_v;
    logic signed [VOLT_W-1:0] first_v;
    logic signed [VOLT_W-1:0] step_v;
    logic signed [VOLT_W-1:0] pulse_v;
    logic signed [VOLT_W-1:0] fwd_delta;
    logic signed [VOLT_W-1:0] stepped_v;
    logic signed [VOLT_W-1:0] fwd_v;
    logic signed [VOLT_W-1:0] rev_v;
    logic signed [VOLT_W-1:0] seg_target;
    logic signed [VOLT_W-1:0] next_target;
    logic [1:0]               seg_after;
    logic                     within_end;
    logic                     within_step;
    logic                     within_seg;

    function automatic logic signed [VOLT_W-1:0] target_of(input logic [1:0] seg,
                                                           input cfg_t c);
        logic signed [VOLT_W-1:0] t;
        if (seg == SEG_FIRST) begin
            t = ext_volt(c.first_vertex);
        end else if (seg == SEG_SECOND) begin
            t = ext_volt(c.second_vertex);
        end else begin
            t = ext_volt(c.end_voltage);
        end
        return t;
    endfunction

    function automatic point_t make_point(input logic signed [VOLT_W-1:0] v,
                                          input logic last);
        point_t p;
        p.voltage = v;
        p.sample  = 1'b1;
        p.done    = 1'b0;
        p.last    = last;
        return p;
    endfunction

    function automatic point_t make_done();
        point_t p;
        p.voltage = '0;
        p.sample  = 1'b0;
        p.done    = 1'b1;
        p.last    = 1'b1;
        return p;
    endfunction

    assign start_v     = ext_volt(cfg.start_voltage);
    assign end_v       = ext_volt(cfg.end_voltage);
    assign first_v     = ext_volt(cfg.first_vertex);
    assign step_v      = VOLT_W'(cfg.step_size);
    assign pulse_v     = VOLT_W'(cfg.pulse_amplitude);
    assign fwd_delta   = step_v + pulse_v;
    assign stepped_v   = up_reg ? volt_reg + step_v : volt_reg - step_v;
    assign fwd_v       = up_reg ? volt_reg + fwd_delta : volt_reg - fwd_delta;
    assign rev_v       = up_reg ? volt_reg - pulse_v : volt_reg + pulse_v;
    assign within_end  = up_reg ? (volt_reg <= end_v) : (volt_reg >= end_v);
    assign within_step = up_reg ? (stepped_v <= end_v) : (stepped_v >= end_v);
    assign seg_target  = target_of(seg_reg, cfg);
    assign seg_after   = (seg_reg >= SEG_LAST) ? SEG_FIRST : seg_reg + 2'd1;
    assign next_target = target_of(seg_after, cfg);
    assign within_seg  = up_reg ? (volt_reg <= seg_target) : (volt_reg >= seg_target);

    always_comb begin
        state_next   = state_reg;
        running_next = running_reg;
        tech_next    = tech_reg;
        seg_next     = seg_reg;
        up_next      = up_reg;
        volt_next    = volt_reg;
        count_next   = count_reg;
        cyc_next     = cyc_reg;
        pop          = 1'b0;
        pt_valid     = 1'b0;
        pt           = make_done();

        unique case (state_reg)
            ST_IDLE: begin
                if (op_valid && pt_ready) begin
                    pop = 1'b1;
                    unique case (op.kind)
                        OP_START: begin
                            running_next = 1'b1;
                            tech_next    = op.technique;
                            volt_next    = start_v;
                            seg_next     = SEG_FIRST;
                            cyc_next     = '0;
                            count_next   = cfg.step_period;
                            if (op.technique == TECH_LINEAR) begin
                                up_next  = end_v > start_v;
                                pt_valid = 1'b1;
                                pt       = make_point(start_v, 1'b1);
                            end else if (op.technique == TECH_CYCLIC) begin
                                up_next    = first_v > start_v;
                                state_next = ST_SEEK;
                            end else begin
                                up_next    = end_v > start_v;
                                pt_valid   = 1'b1;
                                pt         = make_point(start_v, 1'b0);
                                state_next = ST_SQ_FWD;
                            end
                        end
                        OP_TICK: begin
                            if (running_reg) begin
                                if (count_reg > PERIOD_W'(1)) begin
                                    count_next = count_reg - PERIOD_W'(1);
                                end else begin
                                    count_next = cfg.step_period;
                                    if (tech_reg == TECH_LINEAR) begin
                                        volt_next = stepped_v;
                                        pt_valid  = 1'b1;
                                        if (within_step) begin
                                            pt = make_point(stepped_v, 1'b1);
                                        end else begin
                                            running_next = 1'b0;
                                            count_next   = '0;
                                        end
                                    end else if (tech_reg == TECH_CYCLIC) begin
                                        volt_next  = stepped_v;
                                        state_next = ST_SEEK;
                                    end else if (within_end) begin
                                        state_next = ST_SQ_FWD;
                                    end else begin
                                        running_next = 1'b0;
                                        count_next   = '0;
                                        pt_valid     = 1'b1;
                                    end
                                end
                            end
                        end
                        OP_ABORT: begin
                            if (running_reg) begin
                                running_next = 1'b0;
                                count_next   = '0;
                                pt_valid     = 1'b1;
                            end
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SEEK: begin
                if (pt_ready) begin
                    if (cyc_reg < cfg.cycle_count) begin
                        if (within_seg) begin
                            pt_valid   = 1'b1;
                            pt         = make_point(volt_reg, 1'b1);
                            state_next = ST_IDLE;
                        end else begin
                            seg_next = seg_after;
                            up_next  = next_target > seg_target;
                            if (seg_reg >= SEG_LAST) begin
                                cyc_next = cyc_reg + CYC_W'(1);
                            end
                        end
                    end else begin
                        running_next = 1'b0;
                        count_next   = '0;
                        pt_valid     = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_SQ_FWD: begin
                if (pt_ready) begin
                    volt_next  = fwd_v;
                    pt_valid   = 1'b1;
                    pt         = make_point(fwd_v, 1'b0);
                    state_next = ST_SQ_REV;
                end
            end
            ST_SQ_REV: begin
                if (pt_ready) begin
                    volt_next  = rev_v;
                    pt_valid   = 1'b1;
                    pt         = make_point(rev_v, 1'b1);
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            running_reg <= 1'b0;
            tech_reg    <= TECH_LINEAR;
            seg_reg     <= SEG_FIRST;
            up_reg      <= 1'b0;
            volt_reg    <= '0;
            count_reg   <= '0;
            cyc_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            running_reg <= running_next;
            tech_reg    <= tech_next;
            seg_reg     <= seg_next;
            up_reg      <= up_next;
            volt_reg    <= volt_next;
            count_reg   <= count_next;
            cyc_reg     <= cyc_next;
        end
    end

endmodule

>>> rtl/vws_dac_out.sv
// Two-stage DAC mapping and result register: a Q16 multiply, then offset,
// clamp and the output transaction register. Depends on vws_pkg.

module vws_dac_out import vws_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       pt_valid,
    input  point_t                     pt,
    output logic                       pt_ready,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [DAC_BITS-1:0]        m_dac_code,
    output logic signed [OUT_V_W-1:0]  m_applied_voltage,
    output logic                       m_sample_request,
    output logic                       m_sweep_done,
    output logic                       m_last_of_run
);

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    point_t                  s1_pt_reg;
    logic signed [ACC_W-1:0] s1_prod_reg;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic [DAC_BITS-1:0]     code_reg;
    logic [OUT_V_W-1:0]      volt_reg;
    logic                    sample_reg;
    logic                    done_reg;
    logic                    last_reg;

    logic                    m_advance;
    logic                    s1_load;
    logic signed [ACC_W-1:0] volt_wide;
    logic signed [ACC_W-1:0] acc;
    logic [ACC_W-FRAC_BITS-1:0] acc_int;
    logic [DAC_BITS-1:0]     code;

    assign m_advance = !m_valid_reg || m_ready;
    assign s1_load   = !s1_valid_reg || m_advance;
    assign pt_ready  = s1_load;
    assign volt_wide = ACC_W'(pt.voltage);
    assign acc       = s1_prod_reg + OFFSET_Q16;
    assign acc_int   = acc[ACC_W-1:FRAC_BITS];

    always_comb begin
        if (s1_pt_reg.done || acc[ACC_W-1]) begin
            code = '0;
        end else if (acc_int > DAC_MAX_WIDE) begin
            code = DAC_MAX;
        end else begin
            code = acc_int[DAC_BITS-1:0];
        end
        s1_valid_next = s1_load ? pt_valid : s1_valid_reg;
        m_valid_next  = m_advance ? s1_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_pt_reg   <= pt;
            s1_prod_reg <= volt_wide * GAIN_Q16;
        end
        if (m_advance) begin
            code_reg   <= code;
            volt_reg   <= s1_pt_reg.voltage[OUT_V_W-1:0];
            sample_reg <= s1_pt_reg.sample;
            done_reg   <= s1_pt_reg.done;
            last_reg   <= s1_pt_reg.last;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_dac_code        = code_reg;
    assign m_applied_voltage = $signed(volt_reg);
    assign m_sample_request  = sample_reg;
    assign m_sweep_done      = done_reg;
    assign m_last_of_run     = last_reg;

endmodule

>>> rtl/voltammetry_waveform_sequencer.sv
// Top level of the voltammetry waveform sequencer: configuration registers and
// the front end, operation queue, sequencer and DAC stage.
// Depends on vws_pkg, vws_front, vws_queue, vws_back and vws_dac_out.
//
// Commands arrive on the s_ channel (start with a technique, tick, abort);
// waveform points leave on the m_ channel, each with its DAC code, requested
// potential and sample or done flags, the final one of a command marked with
// m_last_of_run. Registers are to be written through the APB port only while
// no command is in flight; the block itself does not enforce this. pready is
// always high and reads return the stored value. The front end takes a
// transaction whenever the two-entry queue has room. The sequencer carries out
// a linear or counting command directly from idle, a square-wave step through
// a forward and a reverse state, and a cyclic step through a seek state that
// skips empty segments. A point reaches m_valid through the multiply stage and
// the output register. If the receiver holds m_ready low, the output register,
// the multiply stage, the sequencer and finally the queue fill in turn and
// s_ready falls; nothing is lost. Reset clears the sweep state, leaves the
// block idle with empty queue and output, and loads the register defaults.

module voltammetry_waveform_sequencer import vws_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_AW-1:0]         paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_command,
    input  logic [1:0]                s_technique,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [DAC_BITS-1:0]       m_dac_code,
    output logic signed [OUT_V_W-1:0] m_applied_voltage,
    output logic                      m_sample_request,
    output logic                      m_sweep_done,
    output logic                      m_last_of_run
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_index;
    logic       wr_en;

    logic       q_full;
    logic       push;
    op_t        push_op;
    logic       pop;
    logic       op_valid;
    op_t        op;
    logic       pt_valid;
    point_t     pt;
    logic       pt_ready;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_AW-1:2];
    assign wr_en     = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_index)
                REG_STEP_PERIOD:     cfg_next.step_period     = pwdata[PERIOD_W-1:0];
                REG_STEP_SIZE:       cfg_next.step_size       = pwdata[STEP_W-1:0];
                REG_START_VOLTAGE:   cfg_next.start_voltage   = pwdata[CFG_V_W-1:0];
                REG_END_VOLTAGE:     cfg_next.end_voltage     = pwdata[CFG_V_W-1:0];
                REG_FIRST_VERTEX:    cfg_next.first_vertex    = pwdata[CFG_V_W-1:0];
                REG_SECOND_VERTEX:   cfg_next.second_vertex   = pwdata[CFG_V_W-1:0];
                REG_CYCLE_COUNT:     cfg_next.cycle_count     = pwdata[CYC_W-1:0];
                REG_PULSE_AMPLITUDE: cfg_next.pulse_amplitude = pwdata[STEP_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_STEP_PERIOD:     prdata = APB_DW'(cfg_reg.step_period);
            REG_STEP_SIZE:       prdata = APB_DW'(cfg_reg.step_size);
            REG_START_VOLTAGE:   prdata = APB_DW'(cfg_reg.start_voltage);
            REG_END_VOLTAGE:     prdata = APB_DW'(cfg_reg.end_voltage);
            REG_FIRST_VERTEX:    prdata = APB_DW'(cfg_reg.first_vertex);
            REG_SECOND_VERTEX:   prdata = APB_DW'(cfg_reg.second_vertex);
            REG_CYCLE_COUNT:     prdata = APB_DW'(cfg_reg.cycle_count);
            REG_PULSE_AMPLITUDE: prdata = APB_DW'(cfg_reg.pulse_amplitude);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_period     <= PERIOD_W'(100);
            cfg_reg.step_size       <= STEP_W'(10);
            cfg_reg.start_voltage   <= '0;
            cfg_reg.end_voltage     <= '0;
            cfg_reg.first_vertex    <= '0;
            cfg_reg.second_vertex   <= '0;
            cfg_reg.cycle_count     <= CYC_W'(1);
            cfg_reg.pulse_amplitude <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    vws_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_technique (s_technique),
        .q_full      (q_full),
        .push        (push),
        .push_op     (push_op)
    );

    vws_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_op  (push_op),
        .full     (q_full),
        .pop      (pop),
        .op_valid (op_valid),
        .op       (op)
    );

    vws_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .op_valid (op_valid),
        .op       (op),
        .pop      (pop),
        .pt_valid (pt_valid),
        .pt       (pt),
        .pt_ready (pt_ready)
    );

    vws_dac_out u_dac_out (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .pt_valid          (pt_valid),
        .pt                (pt),
        .pt_ready          (pt_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_dac_code        (m_dac_code),
        .m_applied_voltage (m_applied_voltage),
        .m_sample_request  (m_sample_request),
        .m_sweep_done      (m_sweep_done),
        .m_last_of_run     (m_last_of_run)
    );

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the voltammetry waveform sequencer: directed and
// random command streams, predicted waveform points checked in order.
// Depends on vws_pkg and the voltammetry_waveform_sequencer top level.

module tb;
    import vws_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam logic [1:0] TECH_UNUSED  = 2'd3;
    localparam int         SETTLE_CYCLES = 800;
    localparam int         DRAIN_LIMIT   = 20000;
    localparam int         RANDOM_ITEMS  = 170;
    localparam int         PHASE_ITEMS   = 25;
    localparam int         TIMEOUT_NS    = 20_000_000;

    localparam longint DAC_FULL   = (longint'(1) << DAC_BITS) - 1;
    localparam longint DAC_GAIN   = (DAC_FULL * 65536 + 8250) / 16500;
    localparam longint DAC_OFFSET = (DAC_FULL * 1703 * 65536 + 2500) / 5000;

    typedef struct packed {
        logic [DAC_BITS-1:0] dac_code;
        logic [OUT_V_W-1:0]  applied_voltage;
        logic                sample_request;
        logic                sweep_done;
        logic                last_of_run;
    } wave_point_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_AW-1:0]         paddr;
    logic [APB_DW-1:0]         pwdata;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;
    logic                      s_valid;
    logic                      s_ready;
    logic [1:0]                s_command;
    logic [1:0]                s_technique;
    logic                      m_valid;
    logic                      m_ready;
    logic [DAC_BITS-1:0]       m_dac_code;
    logic signed [OUT_V_W-1:0] m_applied_voltage;
    logic                      m_sample_request;
    logic                      m_sweep_done;
    logic                      m_last_of_run;

    logic [PERIOD_W-1:0] step_period_reg     = 16'd100;
    logic [STEP_W-1:0]   step_size_reg       = 14'd10;
    logic [CFG_V_W-1:0]  start_voltage_reg   = '0;
    logic [CFG_V_W-1:0]  end_voltage_reg     = '0;
    logic [CFG_V_W-1:0]  first_vertex_reg    = '0;
    logic [CFG_V_W-1:0]  second_vertex_reg   = '0;
    logic [CYC_W-1:0]    cycle_count_reg     = 8'd1;
    logic [STEP_W-1:0]   pulse_amplitude_reg = '0;

    bit         sweep_running   = 1'b0;
    logic [1:0] sweep_technique = TECH_LINEAR;
    logic [1:0] sweep_segment   = SEG_FIRST;
    bit         sweep_rising    = 1'b0;
    int         sweep_volt      = 0;
    int         sweep_countdown = 0;
    int         sweep_cycles    = 0;

    wave_point_t expected_points[$];
    wave_point_t new_points[$];

    bit allow_gaps          = 1'b1;
    int mismatch_count      = 0;
    int points_checked      = 0;
    int commands_sent       = 0;
    int settings_loaded     = 0;

    voltammetry_waveform_sequencer DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [DAC_BITS-1:0] volt_to_code(input int v);
        longint acc;
        acc = longint'(v) * DAC_GAIN + DAC_OFFSET;
        if (acc < 0) return '0;
        acc = acc >>> FRAC_BITS;
        if (acc > DAC_FULL) return DAC_BITS'(DAC_FULL);
        return DAC_BITS'(acc);
    endfunction

    function automatic int wrap_volt(input int v);
        logic signed [VOLT_W-1:0] w;
        w = v[VOLT_W-1:0];
        return int'(w);
    endfunction

    function automatic int sext_volt(input logic [CFG_V_W-1:0] r);
        return int'($signed(r));
    endfunction

    function automatic bit in_segment(input int v, input int target, input bit up);
        return up ? (v <= target) : (v >= target);
    endfunction

    function automatic int segment_target(input logic [1:0] seg);
        case (seg)
            SEG_FIRST:  return sext_volt(first_vertex_reg);
            SEG_SECOND: return sext_volt(second_vertex_reg);
            default:    return sext_volt(end_voltage_reg);
        endcase
    endfunction

    function automatic void shift_volt(input int delta);
        sweep_volt = wrap_volt(sweep_volt + delta);
    endfunction

    function automatic void emit_point();
        new_points.push_back('{volt_to_code(sweep_volt), OUT_V_W'(sweep_volt),
                               1'b1, 1'b0, 1'b0});
    endfunction

    function automatic void emit_done();
        sweep_running   = 1'b0;
        sweep_countdown = 0;
        new_points.push_back('{'0, '0, 1'b0, 1'b1, 1'b0});
    endfunction

    // Empty segments are passed over without output until a segment holds the
    // present potential or every cycle has been used up.
    function automatic void seek_vertex();
        int target;
        while (sweep_cycles < int'(cycle_count_reg)) begin
            target = segment_target(sweep_segment);
            if (in_segment(sweep_volt, target, sweep_rising)) begin
                emit_point();
                return;
            end
            if (sweep_segment == SEG_LAST) begin
                sweep_segment = SEG_FIRST;
                sweep_cycles++;
            end else begin
                sweep_segment = sweep_segment + 2'd1;
            end
            sweep_rising = segment_target(sweep_segment) > target;
        end
        emit_done();
    endfunction

    function automatic bit apply_command(input logic [1:0] cmd, input logic [1:0] tech);
        int          start_v;
        int          end_v;
        int          step;
        int          pulse;
        wave_point_t tail;
        start_v = sext_volt(start_voltage_reg);
        end_v   = sext_volt(end_voltage_reg);
        step    = int'(step_size_reg);
        pulse   = int'(pulse_amplitude_reg);
        new_points.delete();
        case (cmd)
            CMD_START: begin
                if (tech > TECH_SQUARE) return 1'b0;
                sweep_running   = 1'b1;
                sweep_technique = tech;
                sweep_volt      = wrap_volt(start_v);
                sweep_segment   = SEG_FIRST;
                sweep_cycles    = 0;
                sweep_countdown = int'(step_period_reg);
                if (tech == TECH_CYCLIC) begin
                    sweep_rising = sext_volt(first_vertex_reg) > start_v;
                    seek_vertex();
                end else begin
                    sweep_rising = end_v > start_v;
                    emit_point();
                    if (tech == TECH_SQUARE) begin
                        shift_volt(sweep_rising ? pulse + step : -(pulse + step));
                        emit_point();
                        shift_volt(sweep_rising ? -pulse : pulse);
                        emit_point();
                    end
                end
            end
            CMD_TICK: begin
                if (!sweep_running) return 1'b0;
                if (sweep_countdown > 1) begin
                    sweep_countdown--;
                    return 1'b1;
                end
                sweep_countdown = int'(step_period_reg);
                if (sweep_technique == TECH_SQUARE) begin
                    if (in_segment(sweep_volt, end_v, sweep_rising)) begin
                        shift_volt(sweep_rising ? pulse + step : -(pulse + step));
                        emit_point();
                        shift_volt(sweep_rising ? -pulse : pulse);
                        emit_point();
                    end else begin
                        emit_done();
                    end
                end else begin
                    shift_volt(sweep_rising ? step : -step);
                    if (sweep_technique == TECH_CYCLIC)
                        seek_vertex();
                    else if (in_segment(sweep_volt, end_v, sweep_rising))
                        emit_point();
                    else
                        emit_done();
                end
            end
            CMD_ABORT: begin
                if (!sweep_running) return 1'b0;
                emit_done();
            end
            default: return 1'b0;
        endcase
        if (new_points.size() > 0) begin
            tail = new_points.pop_back();
            tail.last_of_run = 1'b1;
            new_points.push_back(tail);
        end
        foreach (new_points[i]) expected_points.push_back(new_points[i]);
        return 1'b1;
    endfunction

    function automatic int rand_volt();
        if ($urandom_range(0, 5) == 0)
            return sext_volt(CFG_V_W'($urandom_range(0, 32767)));
        return int'($urandom_range(0, 15000)) - 5000;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("ERROR at %0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) report_mismatch(name, want, got);
    endtask

    task automatic send_command(input logic [1:0] cmd, input logic [1:0] tech);
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_technique <= tech;
        do @(posedge aclk); while (!s_ready);
        void'(apply_command(cmd, tech));
        commands_sent++;
    endtask

    task automatic wait_for_results();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (expected_points.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_points.size() != 0) begin
            report_mismatch("waveform points never delivered, count", 0,
                            expected_points.size());
            expected_points.delete();
        end
    endtask

    task automatic load_settings(input int period, input int size, input int start_v,
                                 input int end_v, input int vertex1, input int vertex2,
                                 input int cycles, input int pulse);
        int values[8];
        values = '{period, size, start_v, end_v, vertex1, vertex2, cycles, pulse};
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        for (int i = 0; i < 8; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= APB_AW'(i * 4);
            pwdata  <= APB_DW'(values[i]);
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            case (3'(i))
                REG_STEP_PERIOD:     step_period_reg     = values[i][PERIOD_W-1:0];
                REG_STEP_SIZE:       step_size_reg       = values[i][STEP_W-1:0];
                REG_START_VOLTAGE:   start_voltage_reg   = values[i][CFG_V_W-1:0];
                REG_END_VOLTAGE:     end_voltage_reg     = values[i][CFG_V_W-1:0];
                REG_FIRST_VERTEX:    first_vertex_reg    = values[i][CFG_V_W-1:0];
                REG_SECOND_VERTEX:   second_vertex_reg   = values[i][CFG_V_W-1:0];
                REG_CYCLE_COUNT:     cycle_count_reg     = values[i][CYC_W-1:0];
                REG_PULSE_AMPLITUDE: pulse_amplitude_reg = values[i][STEP_W-1:0];
                default: ;
            endcase
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_loaded++;
    endtask

    task automatic test_idle_commands();
        send_command(CMD_TICK, TECH_LINEAR);
        send_command(CMD_ABORT, TECH_SQUARE);
        send_command(CMD_UNUSED, TECH_CYCLIC);
        send_command(CMD_START, TECH_UNUSED);
        send_command(CMD_START, TECH_LINEAR);
        send_command(CMD_START, TECH_SQUARE);
        send_command(CMD_ABORT, TECH_LINEAR);
    endtask

    task automatic test_linear_extremes();
        load_settings(0, 16383, -16384, 16383, 0, 0, 0, 0);
        send_command(CMD_START, TECH_LINEAR);
        repeat (3) send_command(CMD_TICK, TECH_LINEAR);
        load_settings(1, 0, 100, 200, 0, 0, 1, 0);
        send_command(CMD_START, TECH_LINEAR);
        send_command(CMD_TICK, TECH_LINEAR);
        send_command(CMD_ABORT, TECH_LINEAR);
    endtask

    task automatic test_cyclic_segments();
        load_settings(1, 250, 0, 100, 300, -200, 2, 0);
        send_command(CMD_START, TECH_CYCLIC);
        repeat (6) send_command(CMD_TICK, TECH_CYCLIC);
        load_settings(1, 250, 0, 100, 300, -200, 0, 0);
        send_command(CMD_START, TECH_CYCLIC);
        load_settings(0, 10000, 0, -100, -100, -100, 255, 0);
        send_command(CMD_START, TECH_CYCLIC);
        send_command(CMD_TICK, TECH_CYCLIC);
    endtask

    task automatic test_square_wave();
        load_settings(2, 100, -5000, -4500, 0, 0, 1, 16383);
        send_command(CMD_START, TECH_SQUARE);
        repeat (5) send_command(CMD_TICK, TECH_SQUARE);
    endtask

    task automatic test_random_sweeps();
        int         sent;
        int         phase;
        int         r;
        int         period;
        int         size;
        int         cycles;
        int         pulse;
        logic [1:0] cmd;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 19);
            period = (r == 0) ? 65535 : (r == 1) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 3);
            size   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383)
                                                 : $urandom_range(500, 6000);
            r = $urandom_range(0, 9);
            cycles = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(1, 3);
            pulse  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16383)
                                                 : $urandom_range(0, 3000);
            load_settings(period, size, rand_volt(), rand_volt(), rand_volt(), rand_volt(),
                          cycles, pulse);
            allow_gaps = (sent < RANDOM_ITEMS - 40);
            send_command(CMD_START, 2'($urandom_range(0, 2)));
            sent++;
            for (int i = 0; i < PHASE_ITEMS && sent < RANDOM_ITEMS; i++) begin
                r = $urandom_range(0, 99);
                if (r < 78)      cmd = CMD_TICK;
                else if (r < 86) cmd = CMD_START;
                else if (r < 93) cmd = CMD_ABORT;
                else             cmd = CMD_UNUSED;
                send_command(cmd, 2'($urandom_range(0, 3)));
                sent++;
                if (phase == 2 && i == PHASE_ITEMS / 2) wait_for_results();
            end
            phase++;
        end
    endtask

    initial begin
        int          stall_left;
        wave_point_t want;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("unexpected waveform point, applied_voltage", 0,
                                    $unsigned(m_applied_voltage));
                end else begin
                    want = expected_points.pop_front();
                    check_field("dac_code", want.dac_code, m_dac_code);
                    check_field("applied_voltage", want.applied_voltage,
                                $unsigned(m_applied_voltage));
                    check_field("sample_request", want.sample_request, m_sample_request);
                    check_field("sweep_done", want.sweep_done, m_sweep_done);
                    check_field("last_of_run", want.last_of_run, m_last_of_run);
                    points_checked++;
                end
            end
            if (allow_gaps && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 6);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        aresetn     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        s_valid     <= 1'b0;
        s_command   <= CMD_TICK;
        s_technique <= TECH_LINEAR;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_commands();
        test_linear_extremes();
        test_cyclic_segments();
        test_square_wave();
        test_random_sweeps();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Run covered %0d commands and %0d checked waveform points over %0d settings,",
                 commands_sent, points_checked, settings_loaded);
        $display("spanning linear, cyclic and square-wave sweeps, restarts and aborts.");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> voltammetry_waveform_sequencer.f
rtl/vws_pkg.sv
rtl/vws_front.sv
rtl/vws_queue.sv
rtl/vws_back.sv
rtl/vws_dac_out.sv
rtl/voltammetry_waveform_sequencer.sv
verif/tb.sv
